// File: hw/rtl/nnsc_pkg.sv
// Shared types, codes and clamp tables of the nearest-neighbor sensor correction unit.
`timescale 1ns / 1ps
package nnsc_pkg;

  localparam int ENTRY_W = 16;
  localparam int GAIN_W  = 21;
  localparam int OWN_W   = 15;
  localparam int CFG_W   = 15;

  typedef enum logic [1:0] {
    ACT_SAME    = 2'd0,
    ACT_REMOVED = 2'd1,
    ACT_CORR    = 2'd2,
    ACT_NOTNB   = 2'd3
  } action_t;

  localparam logic [1:0] CFG_OWN_X = 2'd0;
  localparam logic [1:0] CFG_OWN_Y = 2'd1;
  localparam logic [1:0] CFG_START = 2'd2;

  localparam logic [1:0] TYPE_TEMP = 2'd0;
  localparam logic [1:0] TYPE_HUM  = 2'd1;
  localparam logic [1:0] TYPE_AIR  = 2'd2;

  localparam logic signed [15:0] READ_REMOVED = -16'sd256;
  localparam logic [OWN_W-1:0]   OWN_RESET    = 15'd5120;

  typedef struct packed {
    logic [3:0]        sender_x;
    logic [3:0]        sender_y;
    logic [1:0]        sender_type;
    logic signed [15:0] reading;
  } in_item_t;

  typedef struct packed {
    action_t           action;
    logic signed [15:0] correction;
    logic [14:0]       own_reading;
    logic [6:0]        neighbor_count;
  } out_item_t;

  // Lower clamp bound in Q8.8; an unknown type only saturates at zero.
  function automatic logic [OWN_W-1:0] type_lo(input logic [1:0] st);
    logic [OWN_W-1:0] v;
    case (st)
      TYPE_TEMP: v = 15'd5120;
      TYPE_HUM:  v = 15'd2560;
      TYPE_AIR:  v = 15'd3840;
      default:   v = 15'd0;
    endcase
    return v;
  endfunction

  // Upper clamp bound in Q8.8; an unknown type saturates at the field maximum.
  function automatic logic [OWN_W-1:0] type_hi(input logic [1:0] st);
    logic [OWN_W-1:0] v;
    case (st)
      TYPE_TEMP: v = 15'd10240;
      TYPE_HUM:  v = 15'd23040;
      TYPE_AIR:  v = 15'd7680;
      default:   v = 15'd32767;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/nearest_neighbor_sensor_correction_unit.sv
// Top level: neighbor table walker, reading update and result register.
`timescale 1ns / 1ps
// Sequence: an item from the own position goes straight to the result register after acceptance.
//   Any other item scans the table, then a shift pass and, for a new entry, an insert may follow,
//   and the result register loads after them. A correction adds the multiply, rounding and
//   update steps and first waits for the gain unit, which starts when the item is accepted.
// Throughput: one item at a time; no new item is accepted until the result register has loaded,
//   the pace being set by the table scan and shift through one read port, the gain wait and output stalls.
// Reset (synchronous, rst_n low): count 0, own position 0, own reading 5120; the table
//   memory is not cleared, only entries below the count are ever read.
module nearest_neighbor_sensor_correction_unit #(
  parameter int TABLE_DEPTH = 128,
  parameter int NEAREST_K   = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  nnsc_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output nnsc_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [nnsc_pkg::CFG_W-1:0]   cfg_wdata
);
  import nnsc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // One-hot sequencer: scan, shift, insert, then the reading update path.
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SCAN   = 9'b000000010,
    ST_SHIFT  = 9'b000000100,
    ST_INSERT = 9'b000001000,
    ST_GAINW  = 9'b000010000,
    ST_MUL    = 9'b000100000,
    ST_ADJ    = 9'b001000000,
    ST_UPD    = 9'b010000000,
    ST_FIN    = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [3:0]         own_x_r, own_x_nxt;
  logic [3:0]         own_y_r, own_y_nxt;
  logic [OWN_W-1:0]   own_r, own_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  in_item_t           item_r, item_nxt;
  logic [7:0]         sd_r, sd_nxt;
  logic               rem_r, rem_nxt;
  logic               found_r, found_nxt;
  logic [CW-1:0]      fidx_r, fidx_nxt;
  logic               posf_r, posf_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      ip_r, ip_nxt;
  logic [CW-1:0]      left_r, left_nxt;
  logic               dv_r, dv_nxt;
  logic [CW-1:0]      di_r, di_nxt;
  logic               up_r, up_nxt;
  logic               near_r, near_nxt;
  action_t            act_r, act_nxt;
  logic signed [15:0] corr_r, corr_nxt;
  logic signed [38:0] p_r, p_nxt;
  logic               neg_r, neg_nxt;
  logic [14:0]        a_r, a_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               gain_start;
  logic               gain_done;
  logic [GAIN_W-1:0]  gain;

  logic               accept;
  logic               same_pos;
  logic signed [9:0]  dx, dy;
  logic [8:0]         sq_dist;
  logic               issue;
  logic               hit;
  logic [38:0]        mag;
  logic signed [16:0] diff;
  logic signed [17:0] nv;
  logic signed [17:0] lo_s, hi_s;
  logic [OWN_W-1:0]   clamped;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign same_pos = (in_data.sender_x == own_x_r) && (in_data.sender_y == own_y_r);
  assign dx       = $signed({6'd0, in_data.sender_x}) - $signed({6'd0, own_x_r});
  assign dy       = $signed({6'd0, in_data.sender_y}) - $signed({6'd0, own_y_r});
  assign sq_dist  = 9'(dx * dx) + 9'(dy * dy);
  assign gain_start = accept && !same_pos && (in_data.reading != READ_REMOVED);

  // A table entry matches when its stored position equals the sender's.
  assign hit = (ram_rdata[15:12] == item_r.sender_x) && (ram_rdata[11:8] == item_r.sender_y);

  assign diff = $signed({item_r.reading[15], item_r.reading}) - $signed({2'b00, own_r});
  assign mag  = p_r[38] ? 39'(-p_r) : p_r;
  assign nv   = neg_r ? $signed({3'b000, own_r}) - $signed({3'b000, a_r})
                      : $signed({3'b000, own_r}) + $signed({3'b000, a_r});
  assign lo_s = $signed({3'b000, type_lo(item_r.sender_type)});
  assign hi_s = $signed({3'b000, type_hi(item_r.sender_type)});

  always_comb begin
    if (nv > hi_s) begin
      clamped = type_hi(item_r.sender_type);
    end else if (nv < lo_s) begin
      clamped = type_lo(item_r.sender_type);
    end else begin
      clamped = nv[14:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    own_x_nxt     = own_x_r;
    own_y_nxt     = own_y_r;
    own_nxt       = own_r;
    count_nxt     = count_r;
    item_nxt      = item_r;
    sd_nxt        = sd_r;
    rem_nxt       = rem_r;
    found_nxt     = found_r;
    fidx_nxt      = fidx_r;
    posf_nxt      = posf_r;
    pos_nxt       = pos_r;
    ip_nxt        = ip_r;
    left_nxt      = left_r;
    dv_nxt        = 1'b0;
    di_nxt        = di_r;
    up_nxt        = up_r;
    near_nxt      = near_r;
    act_nxt       = act_r;
    corr_nxt      = corr_r;
    p_nxt         = p_r;
    neg_nxt       = neg_r;
    a_nxt         = a_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = {item_r.sender_x, item_r.sender_y, sd_r};
    ram_raddr     = ip_r[AW-1:0];
    issue         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt  = in_data;
          sd_nxt    = (sq_dist > 9'd255) ? 8'd255 : sq_dist[7:0];
          rem_nxt   = (in_data.reading == READ_REMOVED);
          corr_nxt  = '0;
          found_nxt = 1'b0;
          posf_nxt  = 1'b0;
          pos_nxt   = count_r;
          ip_nxt    = '0;
          if (same_pos) begin
            act_nxt   = ACT_SAME;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      // Pipelined walk over the table: one read issued and one entry checked per cycle.
      ST_SCAN: begin
        issue = (ip_r != count_r);
        if (issue) begin
          ip_nxt = ip_r + CW'(1);
          dv_nxt = 1'b1;
          di_nxt = ip_r;
        end
        if (dv_r) begin
          if (hit && !found_r) begin
            found_nxt = 1'b1;
            fidx_nxt  = di_r;
          end
          if (!posf_r && (ram_rdata[7:0] >= sd_r)) begin
            posf_nxt = 1'b1;
            pos_nxt  = di_r;
          end
        end
        if (!issue && !dv_r) begin
          if (rem_r) begin
            act_nxt = ACT_REMOVED;
            if (found_r) begin
              // Close the gap: every entry after the match moves down by one.
              left_nxt  = count_r - fidx_r - CW'(1);
              ip_nxt    = fidx_r + CW'(1);
              up_nxt    = 1'b0;
              state_nxt = ST_SHIFT;
            end else begin
              state_nxt = ST_FIN;
            end
          end else if (found_r) begin
            if (fidx_r < CW'(NEAREST_K)) begin
              act_nxt   = ACT_CORR;
              state_nxt = ST_GAINW;
            end else begin
              act_nxt   = ACT_NOTNB;
              state_nxt = ST_FIN;
            end
          end else if (count_r < CW'(TABLE_DEPTH)) begin
            // Open a slot: entries from the insert position up move up by one, top first.
            left_nxt  = count_r - pos_r;
            ip_nxt    = count_r - CW'(1);
            up_nxt    = 1'b1;
            near_nxt  = (pos_r < CW'(NEAREST_K));
            state_nxt = ST_SHIFT;
          end else begin
            act_nxt   = ACT_NOTNB;
            state_nxt = ST_FIN;
          end
        end
      end

      ST_SHIFT: begin
        issue = (left_r != '0);
        if (issue) begin
          ip_nxt   = up_r ? ip_r - CW'(1) : ip_r + CW'(1);
          left_nxt = left_r - CW'(1);
          dv_nxt   = 1'b1;
          di_nxt   = ip_r;
        end
        if (dv_r) begin
          ram_we    = 1'b1;
          ram_waddr = up_r ? AW'(di_r + CW'(1)) : AW'(di_r - CW'(1));
          ram_wdata = ram_rdata;
        end
        if (!issue && !dv_r) begin
          if (up_r) begin
            state_nxt = ST_INSERT;
          end else begin
            count_nxt = count_r - CW'(1);
            state_nxt = ST_FIN;
          end
        end
      end

      ST_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[AW-1:0];
        count_nxt = count_r + CW'(1);
        if (near_r) begin
          act_nxt   = ACT_CORR;
          state_nxt = ST_GAINW;
        end else begin
          act_nxt   = ACT_NOTNB;
          state_nxt = ST_FIN;
        end
      end

      ST_GAINW: begin
        if (gain_done) begin
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        p_nxt     = diff * $signed({1'b0, gain});
        state_nxt = ST_ADJ;
      end

      // Round the signed Q6.32 product to the nearest 1/256 step, ties away from zero.
      ST_ADJ: begin
        neg_nxt   = p_r[38];
        a_nxt     = 15'((mag + 39'd8388608) >> 24);
        state_nxt = ST_UPD;
      end

      ST_UPD: begin
        corr_nxt  = $signed({1'b0, clamped}) - $signed({1'b0, own_r});
        own_nxt   = clamped;
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_nxt.action         = act_r;
          out_nxt.correction     = corr_r;
          out_nxt.own_reading    = own_r;
          out_nxt.neighbor_count = (count_r > CW'(127)) ? 7'd127 : count_r[6:0];
          state_nxt              = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // The user must write configuration only while no item is in flight; the block does not enforce this.
    if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_X: own_x_nxt = cfg_wdata[3:0];
        CFG_OWN_Y: own_y_nxt = cfg_wdata[3:0];
        CFG_START: own_nxt   = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      own_x_r     <= '0;
      own_y_r     <= '0;
      own_r       <= OWN_RESET;
      count_r     <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      own_x_r     <= own_x_nxt;
      own_y_r     <= own_y_nxt;
      own_r       <= own_nxt;
      count_r     <= count_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r  <= item_nxt;
    sd_r    <= sd_nxt;
    rem_r   <= rem_nxt;
    found_r <= found_nxt;
    fidx_r  <= fidx_nxt;
    posf_r  <= posf_nxt;
    pos_r   <= pos_nxt;
    ip_r    <= ip_nxt;
    left_r  <= left_nxt;
    di_r    <= di_nxt;
    up_r    <= up_nxt;
    near_r  <= near_nxt;
    act_r   <= act_nxt;
    corr_r  <= corr_nxt;
    p_r     <= p_nxt;
    neg_r   <= neg_nxt;
    a_r     <= a_nxt;
    out_r   <= out_nxt;
  end

  nnsc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nnsc_gain u_gain (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (gain_start),
    .sq_dist (sq_dist),
    .done    (gain_done),
    .gain    (gain)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("neighbor count exceeds table depth");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> !ram_we)
    else $error("table written during scan");

  a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) && ram_we && issue |-> ram_waddr != ram_raddr)
    else $error("shift write collides with read");

  a_mul_after_gain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_GAINW && state_nxt == ST_MUL |-> gain_done)
    else $error("multiply started before gain ready");

  a_corr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.action != ACT_CORR) |-> out_r.correction == 16'sd0)
    else $error("nonzero correction without correction action");
`endif

endmodule

// File: hw/rtl/nnsc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module nnsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/nnsc_gain.sv
// Gain unit: bit-serial square root and restoring division giving 0.1/(d+1) in Q0.24.
`timescale 1ns / 1ps
module nnsc_gain (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [8:0]                 sq_dist,
  output logic                       done,
  output logic [nnsc_pkg::GAIN_W-1:0] gain
);
  import nnsc_pkg::*;

  typedef enum logic [4:0] {
    G_IDLE = 5'b00001,
    G_SQRT = 5'b00010,
    G_DEN  = 5'b00100,
    G_NUM  = 5'b01000,
    G_DIV  = 5'b10000
  } gstate_t;

  gstate_t           gst_r, gst_nxt;
  logic [40:0]       rem_r, rem_nxt;
  logic [40:0]       res_r, res_nxt;
  logic [40:0]       bit_r, bit_nxt;
  logic [40:0]       num_r, num_nxt;
  logic [25:0]       den_r, den_nxt;
  logic [25:0]       drem_r, drem_nxt;
  logic [GAIN_W-1:0] q_r, q_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [40:0]       trial;
  logic [21:0]       root_ofs;
  logic [26:0]       shifted;

  always_comb begin
    gst_nxt  = gst_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    drem_nxt = drem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    trial    = res_r + bit_r;
    root_ofs = {1'b0, res_r[20:0]} + 22'd65536;
    shifted  = {drem_r, num_r[40]};
    case (gst_r)
      G_SQRT: begin
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == 41'd1) begin
          gst_nxt = G_DEN;
        end
      end
      G_DEN: begin
        den_nxt = {1'b0, root_ofs, 3'b000} + {3'b000, root_ofs, 1'b0};
        gst_nxt = G_NUM;
      end
      G_NUM: begin
        num_nxt  = {1'b1, 40'd0} + {16'd0, den_r[25:1]};
        drem_nxt = '0;
        q_nxt    = '0;
        cnt_nxt  = '0;
        gst_nxt  = G_DIV;
      end
      G_DIV: begin
        if (shifted >= {1'b0, den_r}) begin
          drem_nxt = 26'(shifted - {1'b0, den_r});
          q_nxt    = {q_r[GAIN_W-2:0], 1'b1};
        end else begin
          drem_nxt = shifted[25:0];
          q_nxt    = {q_r[GAIN_W-2:0], 1'b0};
        end
        num_nxt = {num_r[39:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd40) begin
          done_nxt = 1'b1;
          gst_nxt  = G_IDLE;
        end
      end
      default: begin
      end
    endcase
    if (start) begin
      rem_nxt  = {sq_dist, 32'd0};
      res_nxt  = '0;
      bit_nxt  = {1'b1, 40'd0};
      done_nxt = 1'b0;
      gst_nxt  = G_SQRT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gst_r  <= G_IDLE;
      done_r <= 1'b0;
    end else begin
      gst_r  <= gst_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    drem_r <= drem_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign gain = q_r;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench of the nearest-neighbor sensor correction unit.
`timescale 1ns / 1ps
module tb_top;
  import nnsc_pkg::*;

  localparam int TAB_DEPTH  = 128;
  localparam int NEAR_K     = 3;
  localparam int DRAIN_WAIT = 300;    // Longer than the slowest item.
  localparam int STALL_MAX  = 20000;  // Cycles without any accepted item or returned result before giving up.

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_OWN_X;
  logic [CFG_W-1:0] cfg_wdata = '0;

  nearest_neighbor_sensor_correction_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block state used to predict every result.
  logic [15:0] nb_tab [TAB_DEPTH];
  int          nb_count;
  int          own_val;
  int          pos_x, pos_y;

  out_item_t expected_q[$];
  int        accepted_items;
  int        errors;
  bit        idle_en;

  // A directed row may carry a fixed expectation that replaces the prediction.
  bit        fixed_use;
  out_item_t fixed_exp;

  // Exact integer square root of a 64-bit value.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  function automatic bit at_pos(logic [15:0] e, int x, int y);
    return (int'(e[15:12]) == x) && (int'(e[11:8]) == y);
  endfunction

  // Applies one report to the mirrored state and returns the expected result.
  function automatic out_item_t correct_reading(in_item_t it);
    out_item_t       res;
    int              sx, sy, st, rd, dx, dy, sq, sq_sat, i, lim, ipos;
    bit              known;
    longint unsigned root, den, gain;
    longint          prod, mag, adj, nv;
    sx = it.sender_x;
    sy = it.sender_y;
    st = it.sender_type;
    rd = int'(it.reading);
    res.correction = '0;
    if (sx == pos_x && sy == pos_y) begin
      res.action = ACT_SAME;
    end else if (it.reading == READ_REMOVED) begin
      res.action = ACT_REMOVED;
      for (i = 0; i < nb_count; i++) begin
        if (at_pos(nb_tab[i], sx, sy)) begin
          for (; i + 1 < nb_count; i++) nb_tab[i] = nb_tab[i + 1];
          nb_count--;
          break;
        end
      end
    end else begin
      dx = sx - pos_x;
      dy = sy - pos_y;
      sq = dx * dx + dy * dy;
      sq_sat = (sq > 255) ? 255 : sq;
      known = 1'b0;
      for (i = 0; i < nb_count; i++)
        if (at_pos(nb_tab[i], sx, sy)) known = 1'b1;
      if (!known && nb_count < TAB_DEPTH) begin
        ipos = 0;
        while (ipos < nb_count && int'(nb_tab[ipos][7:0]) < sq_sat) ipos++;
        for (i = nb_count; i > ipos; i--) nb_tab[i] = nb_tab[i - 1];
        nb_tab[ipos] = {it.sender_x, it.sender_y, 8'(sq_sat)};
        nb_count++;
      end
      res.action = ACT_NOTNB;
      lim = (nb_count < NEAR_K) ? nb_count : NEAR_K;
      for (i = 0; i < lim; i++)
        if (at_pos(nb_tab[i], sx, sy)) res.action = ACT_CORR;
      if (res.action == ACT_CORR) begin
        root = int_sqrt(longint'(sq) << 32);
        den  = 10 * (root + 65536);
        gain = ((64'd1 << 40) + den / 2) / den;
        prod = longint'(rd - own_val) * longint'(gain);
        mag  = (prod < 0) ? -prod : prod;
        adj  = (mag + (64'sd1 << 23)) >>> 24;
        nv   = own_val + ((prod < 0) ? -adj : adj);
        if (nv > longint'(type_hi(it.sender_type))) nv = type_hi(it.sender_type);
        if (nv < longint'(type_lo(it.sender_type))) nv = type_lo(it.sender_type);
        res.correction = 16'(int'(nv) - own_val);
        own_val = int'(nv);
      end
    end
    res.own_reading = 15'(own_val);
    res.neighbor_count = 7'((nb_count > 127) ? 127 : nb_count);
    return res;
  endfunction

  // Acceptance side: registers, reports and results are all taken at the rising edge.
  int quiet_cycles;
  always @(posedge clk) begin
    out_item_t exp_item, pred;
    if (!rst_n) begin
      nb_count = 0;
      own_val  = OWN_RESET;
      pos_x    = 0;
      pos_y    = 0;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_X: pos_x = cfg_wdata[3:0];
          CFG_OWN_Y: pos_y = cfg_wdata[3:0];
          CFG_START: own_val = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pred = correct_reading(in_data);
        expected_q.push_back(fixed_use ? fixed_exp : pred);
        accepted_items++;
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (expected_q.size() == 0) begin
          $error("unexpected result: action %0d", out_data.action);
          errors++;
        end else begin
          exp_item = expected_q.pop_front();
          if (out_data.action !== exp_item.action) begin
            $error("action: expected %0d, got %0d", exp_item.action, out_data.action);
            errors++;
          end
          if (out_data.correction !== exp_item.correction) begin
            $error("correction: expected %0d, got %0d",
                   exp_item.correction, out_data.correction);
            errors++;
          end
          if (out_data.own_reading !== exp_item.own_reading) begin
            $error("own_reading: expected %0d, got %0d",
                   exp_item.own_reading, out_data.own_reading);
            errors++;
          end
          if (out_data.neighbor_count !== exp_item.neighbor_count) begin
            $error("neighbor_count: expected %0d, got %0d",
                   exp_item.neighbor_count, out_data.neighbor_count);
            errors++;
          end
        end
      end
      if (quiet_cycles >= STALL_MAX) begin
        $display("nearest_neighbor_sensor_correction_unit regression: fail");
        $finish;
      end
    end
  end

  // The result side stalls in random bursts while idling is enabled.
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one item and returns at the falling edge after it was accepted.
  task automatic send_item(in_item_t it, bit use_fixed, out_item_t fixed);
    int seen;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    seen = accepted_items;
    in_valid  <= 1'b1;
    in_data   <= it;
    fixed_use <= use_fixed;
    fixed_exp <= fixed;
    @(negedge clk);
    while (accepted_items == seen) @(negedge clk);
  endtask

  // Waits until every result is back, then lets the block settle before a register write.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_item_t mk_item(int x, int y, logic [1:0] st, int rd);
    in_item_t it;
    it.sender_x = 4'(x);
    it.sender_y = 4'(y);
    it.sender_type = st;
    it.reading = 16'(rd);
    return it;
  endfunction

  function automatic out_item_t mk_result(action_t act, int corr, int own, int cnt);
    out_item_t r;
    r.action = act;
    r.correction = 16'(corr);
    r.own_reading = 15'(own);
    r.neighbor_count = 7'(cnt);
    return r;
  endfunction

  // Random report: mostly well-formed readings near the clamp ranges, some removals,
  // some full-range noise; wide phases use every coordinate the fields can carry.
  function automatic in_item_t random_item(bit wide);
    int x, y, rd, sel;
    logic [1:0] st;
    x  = wide ? $urandom_range(0, 15) : $urandom_range(0, 9);
    y  = wide ? $urandom_range(0, 15) : $urandom_range(0, 9);
    st = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    sel = $urandom_range(0, 99);
    if (sel < (wide ? 4 : 15)) rd = int'(READ_REMOVED);
    else if (sel < 30) rd = int'($urandom_range(0, 65535)) - 32768;
    else rd = $urandom_range(0, 25600);
    return mk_item(x, y, st, rd);
  endfunction

  typedef struct {
    in_item_t  it;
    bit        has_exp;
    out_item_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    int ph, n, items_left;
    int cfg_x[5];
    int cfg_y[5];
    int cfg_s[5];
    cfg_x = '{9, 0, 5, 15, 3};
    cfg_y = '{9, 9, 4, 15, 7};
    cfg_s = '{25600, 0, 12345, 32767, 5120};
    errors = 0;
    accepted_items = 0;
    idle_en = 1'b1;
    fixed_use = 1'b0;
    fixed_exp = '0;

    // Directed part, own position (0,0) and own reading 20.0 right after reset.
    dir_rows.push_back('{mk_item(0, 0, TYPE_TEMP, -256), 1, mk_result(ACT_SAME, 0, 5120, 0)});
    dir_rows.push_back('{mk_item(1, 0, TYPE_TEMP, -256), 1,
                         mk_result(ACT_REMOVED, 0, 5120, 0)});
    dir_rows.push_back('{mk_item(0, 0, TYPE_AIR, 32767), 1, mk_result(ACT_SAME, 0, 5120, 0)});
    dir_rows.push_back('{mk_item(1, 0, TYPE_TEMP, 32767), 0, '0});
    dir_rows.push_back('{mk_item(0, 1, TYPE_HUM, -32768), 0, '0});
    dir_rows.push_back('{mk_item(1, 1, TYPE_AIR, 0), 0, '0});
    dir_rows.push_back('{mk_item(15, 15, 2'd3, 25600), 0, '0});
    dir_rows.push_back('{mk_item(1, 0, TYPE_TEMP, 5000), 0, '0});
    dir_rows.push_back('{mk_item(2, 2, 2'd3, -32768), 0, '0});
    dir_rows.push_back('{mk_item(9, 9, TYPE_HUM, 23040), 0, '0});
    dir_rows.push_back('{mk_item(1, 1, TYPE_HUM, -255), 0, '0});
    dir_rows.push_back('{mk_item(0, 1, TYPE_HUM, -256), 0, '0});
    dir_rows.push_back('{mk_item(15, 0, TYPE_TEMP, 10240), 0, '0});
    dir_rows.push_back('{mk_item(1, 0, TYPE_TEMP, 20000), 0, '0});
    dir_rows.push_back('{mk_item(15, 15, 2'd3, -256), 0, '0});
    dir_rows.push_back('{mk_item(0, 15, TYPE_AIR, 3840), 0, '0});

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].has_exp, dir_rows[i].res);

    // Random phases, each behind a fresh register setting; phases one and three use the
    // whole coordinate range so that the table fills up.
    items_left = 1700;
    for (ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(CFG_OWN_X, cfg_x[ph]);
      write_reg(CFG_OWN_Y, cfg_y[ph]);
      write_reg(CFG_START, cfg_s[ph]);
      n = (ph == 4) ? items_left : 340;
      for (int i = 0; i < n; i++) begin
        if (ph == 4 && i > n / 2) idle_en = 1'b0;
        send_item(random_item(ph == 3 || ph == 1), 1'b0, '0);
      end
      items_left -= n;
    end

    drain();
    if (errors == 0) begin
      $display("nearest_neighbor_sensor_correction_unit regression: pass");
    end else begin
      $display("nearest_neighbor_sensor_correction_unit regression: fail");
    end
    $finish;
  end

endmodule
